/* sv/cdms_pkg.sv */
// ----------------------------------------------------------------------------
// cdms_pkg
// Shared types, marker patterns and helpers for the CDATA marker stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package cdms_pkg;

    // Window cells: up to eight held bytes plus the incoming item.
    localparam int CELLS     = 9;
    localparam int OPEN_LEN  = 9;
    localparam int CLOSE_LEN = 3;

    // Opener "<![CDATA[" with its letters already folded to lower case;
    // element 0 is the first character of the marker.
    localparam logic [OPEN_LEN-1:0][7:0] OPEN_FOLDED =
        {8'h5B, 8'h61, 8'h74, 8'h61, 8'h64, 8'h63, 8'h5B, 8'h21, 8'h3C};

    // Closer "]]>", matched exactly; element 0 is the first character.
    localparam logic [CLOSE_LEN-1:0][7:0] CLOSE_PAT = {8'h3E, 8'h5D, 8'h5D};

    // Commands broadcast to every cell of the window.
    typedef struct packed {
        logic load;    // the first empty cell takes the incoming byte
        logic shift1;  // every cell takes its right neighbor's content
        logic shift3;  // every cell takes the content three places to its right
        logic clear;   // the whole window is emptied
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_FINISH
    } t_state;

    // Only ASCII upper-case letters fold; every other byte matches itself.
    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cdata_marker_stripper_core.sv */
// Items are handled one at a time: a new item is taken only once the last one is through. The
// scan then releases a front byte, deletes a marker or decides to end, step by step, and stalls
// while a byte is pending and the output register is full; a closing step passes on the last result.
// Results come straight from the output register, which holds each one until it is taken.
// Reset (synchronous, active low) empties the window and the output side and closes any open
// section; the held byte contents are not cleared.
// ----------------------------------------------------------------------------
// cdata_marker_stripper_core
// Byte stream filter that deletes CDATA openers and, inside a section, the
// closers, using a nine-cell window that shifts toward its front.
// ----------------------------------------------------------------------------
`default_nettype none

module cdata_marker_stripper_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // end_of_stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // run_last
    output logic [1:0]       m_axis_tuser    // [0] has_byte, [1] stream_done
);
    import cdms_pkg::*;

    // The window is a row of cells. Cell 0 is the front, i.e. the oldest
    // byte. Valid cells are always contiguous from the front, so the incoming
    // item lands in the first empty cell and a release is a shift by one.
    t_cell_cmd              cmd;
    logic [CELLS-1:0][7:0]  cell_byte;
    logic [CELLS-1:0]       cell_valid;
    logic [CELLS-1:0]       open_ok;
    logic [CELLS-1:0]       close_ok;

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++) begin : g_cell
            logic [7:0] nb1_byte;
            logic       nb1_valid;
            logic [7:0] nb3_byte;
            logic       nb3_valid;
            logic       prev_valid;
            logic [7:0] close_ch;
            logic       close_en;

            if (gi + 1 < CELLS) begin : g_nb1
                assign nb1_byte  = cell_byte[gi+1];
                assign nb1_valid = cell_valid[gi+1];
            end else begin : g_nb1_end
                assign nb1_byte  = 8'h00;
                assign nb1_valid = 1'b0;
            end

            if (gi + 3 < CELLS) begin : g_nb3
                assign nb3_byte  = cell_byte[gi+3];
                assign nb3_valid = cell_valid[gi+3];
            end else begin : g_nb3_end
                assign nb3_byte  = 8'h00;
                assign nb3_valid = 1'b0;
            end

            if (gi == 0) begin : g_front
                assign prev_valid = 1'b1;
            end else begin : g_rest
                assign prev_valid = cell_valid[gi-1];
            end

            if (gi < CLOSE_LEN) begin : g_close
                assign close_ch = CLOSE_PAT[gi];
                assign close_en = 1'b1;
            end else begin : g_noclose
                assign close_ch = 8'h00;
                assign close_en = 1'b0;
            end

            cdms_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_in_byte    (s_axis_tdata),
                .i_prev_valid (prev_valid),
                .i_nb1_byte   (nb1_byte),
                .i_nb1_valid  (nb1_valid),
                .i_nb3_byte   (nb3_byte),
                .i_nb3_valid  (nb3_valid),
                .i_open_ch    (OPEN_FOLDED[gi]),
                .i_close_ch   (close_ch),
                .i_close_en   (close_en),
                .o_byte       (cell_byte[gi]),
                .o_valid      (cell_valid[gi]),
                .o_open_ok    (open_ok[gi]),
                .o_close_ok   (close_ok[gi])
            );
        end
    endgenerate

    // Match state of the window front. "Full" needs every marker position
    // filled; "partial" means the front could still grow into the marker.
    logic open_full;
    logic open_part;
    logic close_full;
    logic close_part;

    assign open_full  = (&open_ok) && cell_valid[OPEN_LEN-1];
    assign open_part  = (&open_ok) && !cell_valid[OPEN_LEN-1];
    assign close_full = (&close_ok) && cell_valid[CLOSE_LEN-1];
    assign close_part = (&close_ok) && !cell_valid[CLOSE_LEN-1];

    // Control state. The most recently released byte waits in a pending
    // register, because only the end of the scan tells whether it is the
    // last result of its item.
    t_state     r_state;
    t_state     n_state;
    logic       r_inside;
    logic       n_inside;
    logic       r_eos;
    logic       n_eos;
    logic       r_pend_valid;
    logic       n_pend_valid;
    logic [7:0] r_pend_byte;
    logic [7:0] n_pend_byte;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_has;
    logic       r_out_last;
    logic       r_out_done;

    logic       push_ok;
    logic       push;
    logic [7:0] push_byte;
    logic       push_has;
    logic       push_last;
    logic       push_done;
    logic       release_req;

    assign push_ok = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_inside     = r_inside;
        n_eos        = r_eos;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        cmd          = '0;
        push         = 1'b0;
        push_byte    = r_pend_byte;
        push_has     = 1'b1;
        push_last    = 1'b0;
        push_done    = 1'b0;
        release_req  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load = 1'b1;
                    n_eos    = s_axis_tlast;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // The opener is always tried before the closer.
                if (!cell_valid[0]) begin
                    n_state = r_eos ? S_FLUSH : S_FINISH;
                end else if (open_full) begin
                    cmd.clear = 1'b1;
                    n_inside  = 1'b1;
                end else if (open_part) begin
                    n_state = r_eos ? S_FLUSH : S_FINISH;
                end else if (r_inside && close_full) begin
                    cmd.shift3 = 1'b1;
                    n_inside   = 1'b0;
                end else if (r_inside && close_part) begin
                    n_state = r_eos ? S_FLUSH : S_FINISH;
                end else begin
                    release_req = 1'b1;
                end
            end
            S_FLUSH: begin
                // A marker cut short by the end of the document passes through.
                if (!cell_valid[0]) begin
                    n_state = S_FINISH;
                end else begin
                    release_req = 1'b1;
                end
            end
            S_FINISH: begin
                if (r_pend_valid || r_eos) begin
                    if (push_ok) begin
                        push         = 1'b1;
                        push_byte    = r_pend_valid ? r_pend_byte : 8'h00;
                        push_has     = r_pend_valid;
                        push_last    = 1'b1;
                        push_done    = r_eos;
                        n_pend_valid = 1'b0;
                        n_eos        = 1'b0;
                        if (r_eos) begin
                            n_inside = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Releasing the front byte moves the previous pending byte out as a
        // result that is not the last of its item. A release stalls while a byte
        // is pending and the output register is full.
        if (release_req && (!r_pend_valid || push_ok)) begin
            push         = r_pend_valid;
            cmd.shift1   = 1'b1;
            n_pend_valid = 1'b1;
            n_pend_byte  = cell_byte[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_inside     <= 1'b0;
            r_eos        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_inside     <= n_inside;
            r_eos        <= n_eos;
            r_pend_valid <= n_pend_valid;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_byte <= n_pend_byte;
        if (push) begin
            r_out_byte <= push_byte;
            r_out_has  <= push_has;
            r_out_last <= push_last;
            r_out_done <= push_done;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_done, r_out_has};

`ifndef NO_ASSERTIONS
    // Deleting an opener empties the whole window.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |=> (cell_valid == '0))
        else $error("window not empty after opener deletion");

    // Between items at most eight bytes are held back.
    a_hold_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !cell_valid[CELLS-1])
        else $error("more than eight bytes held between items");

    // Valid cells always form a run starting at the front.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid + CELLS'(1)) & cell_valid) == '0)
        else $error("window valid bits not contiguous");

    // The final result of a document also closes its item's run.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> r_out_last)
        else $error("stream_done without run_last");

    // A document end leaves no open section and no held bytes.
    a_doc_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_done) |=> (!r_inside && (cell_valid == '0)))
        else $error("state not cleared after end of stream");
`endif

endmodule

`default_nettype wire

/* sv/cdms_cell.sv */
// ----------------------------------------------------------------------------
// cdms_cell
// One window position: holds a byte and its valid bit, shifts from its
// neighbors and compares its byte against the marker characters at its place.
// ----------------------------------------------------------------------------
`default_nettype none

module cdms_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cdms_pkg::t_cell_cmd  i_cmd,
    input  wire logic [7:0]           i_in_byte,
    input  wire logic                 i_prev_valid,
    input  wire logic [7:0]           i_nb1_byte,
    input  wire logic                 i_nb1_valid,
    input  wire logic [7:0]           i_nb3_byte,
    input  wire logic                 i_nb3_valid,
    input  wire logic [7:0]           i_open_ch,
    input  wire logic [7:0]           i_close_ch,
    input  wire logic                 i_close_en,
    output logic [7:0]                o_byte,
    output logic                      o_valid,
    output logic                      o_open_ok,
    output logic                      o_close_ok
);
    import cdms_pkg::*;

    logic [7:0] r_byte;
    logic       r_valid;
    logic [7:0] n_byte;
    logic       n_valid;

    always_comb begin
        n_byte  = r_byte;
        n_valid = r_valid;
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end else if (i_cmd.shift3) begin
            n_byte  = i_nb3_byte;
            n_valid = i_nb3_valid;
        end else if (i_cmd.shift1) begin
            n_byte  = i_nb1_byte;
            n_valid = i_nb1_valid;
        end else if (i_cmd.load && i_prev_valid && !r_valid) begin
            n_byte  = i_in_byte;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // An empty cell never breaks a match; it only keeps it partial.
    assign o_open_ok  = !r_valid || (fold_byte(r_byte) == i_open_ch);
    assign o_close_ok = !r_valid || !i_close_en || (r_byte == i_close_ch);
    assign o_byte     = r_byte;
    assign o_valid    = r_valid;

endmodule

`default_nettype wire

/* dv/cdata_marker_stripper_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdata_marker_stripper_core_tb
// Self-checking bench for the CDATA marker stripper. A short table of
// directed documents is followed by random documents that are built from
// whole, cut and damaged markers mixed with free bytes. Every accepted item
// runs through a marker-stripping predictor. Each result on the output stream
// is checked against the oldest expected result. Both stream sides are paced
// at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module cdata_marker_stripper_core_tb;

    localparam int RANDOM_ITEMS = 300;
    localparam int LONG_HOLD    = 160;
    localparam int DRAIN_CYCLES = 30;

    // Opener in lower case, since letters match without regard to case.
    localparam logic [0:8][7:0] OPEN_LOW  = "<![cdata[";
    localparam logic [0:2][7:0] CLOSE_SEQ = "]]>";

    typedef enum int {M_NONE, M_PART, M_FULL} match_t;

    typedef enum int {PACE_FULL, PACE_HALF, PACE_SPARSE, PACE_MOSTLY} pace_t;

    typedef enum int {
        FR_OPEN, FR_OPEN_CUT, FR_OPEN_BAD, FR_CLOSE, FR_CLOSE_CUT, FR_MARK_CHAR, FR_ANY
    } frag_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_last;
        logic       done;
    } out_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       pin;        // expected result typed in below
        logic [7:0] pin_data;
        logic       pin_has;
    } stim_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;    // end_of_stream
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // run_last
    logic [1:0] m_axis_tuser;           // [0] has_byte, [1] stream_done

    // Predictor state: the bytes of a partial marker and the section flag.
    logic [7:0] pend_bytes [$];
    bit         section_open = 1'b0;
    out_item_t  fresh_results [$];
    out_item_t  expected_out [$];
    logic [7:0] doc_bytes [$];

    bit failed      = 1'b0;
    bit hold_armed  = 1'b0;
    int burst_left  = 0;

    // Directed documents. Single-result rows at the end of a document carry
    // their expected byte; all the other rows go through the predictor.
    stim_row_t directed_rows [25] = '{
        '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1},   // smallest byte, alone
        '{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},   // largest byte, alone
        '{"<",   1'b0, 1'b0, 8'h00, 1'b0},   // mixed-case opener, then the end
        '{"!",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"[",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"C",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"d",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"A",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"t",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"A",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"[",   1'b1, 1'b1, 8'h00, 1'b0},   // nothing left: empty end marker
        '{"<",   1'b0, 1'b0, 8'h00, 1'b0},   // upper-case opener opens a section
        '{"!",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"[",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"C",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"D",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"A",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"T",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"A",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"[",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"a",   1'b0, 1'b0, 8'h00, 1'b0},   // section content passes through
        '{"]",   1'b0, 1'b0, 8'h00, 1'b0},   // closer ends the section
        '{"]",   1'b0, 1'b0, 8'h00, 1'b0},
        '{">",   1'b0, 1'b0, 8'h00, 1'b0},
        '{"<",   1'b1, 1'b1, "<",   1'b1}    // opener cut short by the end
    };

    cdata_marker_stripper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Only ASCII capitals fold; bytes with the top bit set match themselves.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic match_t opener_match();
        int k;
        for (k = 0; k < 9 && k < pend_bytes.size(); k++) begin
            if (to_lower(pend_bytes[k]) != OPEN_LOW[k]) begin
                return M_NONE;
            end
        end
        return (pend_bytes.size() >= 9) ? M_FULL : M_PART;
    endfunction

    function automatic match_t closer_match();
        int k;
        for (k = 0; k < 3 && k < pend_bytes.size(); k++) begin
            if (pend_bytes[k] != CLOSE_SEQ[k]) begin
                return M_NONE;
            end
        end
        return (pend_bytes.size() >= 3) ? M_FULL : M_PART;
    endfunction

    function automatic void drop_front(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            void'(pend_bytes.pop_front());
        end
    endfunction

    function automatic void release_byte(input logic [7:0] b, input logic has);
        out_item_t r;
        r.data     = b;
        r.has_byte = has;
        r.run_last = 1'b0;
        r.done     = 1'b0;
        fresh_results.push_back(r);
    endfunction

    // Works out the results of one input byte into fresh_results.
    function automatic void strip_predict(input logic [7:0] b, input bit eos);
        match_t mo;
        match_t mc;
        bit     scanning;
        fresh_results.delete();
        pend_bytes.push_back(b);
        scanning = 1'b1;
        while (scanning && pend_bytes.size() > 0) begin
            mo = opener_match();
            mc = section_open ? closer_match() : M_NONE;
            if (mo == M_FULL) begin
                drop_front(9);
                section_open = 1'b1;
            end else if (mo == M_PART) begin
                scanning = 1'b0;
            end else if (mc == M_FULL) begin
                drop_front(3);
                section_open = 1'b0;
            end else if (mc == M_PART) begin
                scanning = 1'b0;
            end else begin
                release_byte(pend_bytes.pop_front(), 1'b1);
            end
        end
        if (eos) begin
            // A marker cut short at the end cannot match: flush what is held.
            while (pend_bytes.size() > 0) begin
                release_byte(pend_bytes.pop_front(), 1'b1);
            end
            if (fresh_results.size() == 0) begin
                release_byte(8'h00, 1'b0);
            end
            fresh_results[fresh_results.size()-1].done = 1'b1;
            section_open = 1'b0;
        end
        if (fresh_results.size() > 0) begin
            fresh_results[fresh_results.size()-1].run_last = 1'b1;
        end
    endfunction

    // Offers one item, waits for it to be taken, then records what it causes.
    // Between bursts the valid line may drop for a random gap.
    task automatic send_byte(input logic [7:0] b, input bit eos, input bit pin,
                             input out_item_t pinned);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        strip_predict(b, eos);
        if (pin) begin
            expected_out.push_back(pinned);
        end else begin
            foreach (fresh_results[k]) begin
                expected_out.push_back(fresh_results[k]);
            end
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Appends one random piece of a document; most pieces are markers.
    function automatic void add_fragment();
        int         kind_sel;
        frag_t      kind;
        int         len;
        int         k;
        int         bad_pos;
        logic [7:0] c;
        kind_sel = $urandom_range(0, 15);
        case (kind_sel)
            0, 1, 2, 3: kind = FR_OPEN;
            4:          kind = FR_OPEN_CUT;
            5:          kind = FR_OPEN_BAD;
            6, 7, 8:    kind = FR_CLOSE;
            9:          kind = FR_CLOSE_CUT;
            10, 11:     kind = FR_MARK_CHAR;
            default:    kind = FR_ANY;
        endcase
        case (kind)
            FR_OPEN, FR_OPEN_CUT, FR_OPEN_BAD: begin
                len = (kind == FR_OPEN_CUT) ? $urandom_range(1, 8) : 9;
                bad_pos = (kind == FR_OPEN_BAD) ? $urandom_range(0, 8) : -1;
                for (k = 0; k < len; k++) begin
                    c = OPEN_LOW[k];
                    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
                        c = c - 8'd32;
                    end
                    // A damaged byte differs in the top bit or the case bit.
                    if (k == bad_pos) begin
                        c = c ^ ($urandom_range(0, 1) ? 8'h80 : 8'h20);
                    end
                    doc_bytes.push_back(c);
                end
            end
            FR_CLOSE: begin
                for (k = 0; k < 3; k++) begin
                    doc_bytes.push_back(CLOSE_SEQ[k]);
                end
            end
            FR_CLOSE_CUT: begin
                len = $urandom_range(1, 2);
                for (k = 0; k < len; k++) begin
                    doc_bytes.push_back("]");
                end
            end
            FR_MARK_CHAR: begin
                k = $urandom_range(0, 9);
                doc_bytes.push_back((k == 9) ? CLOSE_SEQ[2] : OPEN_LOW[k]);
            end
            default: begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) begin
                    doc_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        endcase
    endfunction

    // Stimulus and end of run.
    initial begin
        int        row;
        int        frags;
        int        random_sent;
        out_item_t pinned;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < 25; row++) begin
            pinned.data     = directed_rows[row].pin_data;
            pinned.has_byte = directed_rows[row].pin_has;
            pinned.run_last = 1'b1;
            pinned.done     = 1'b1;
            send_byte(directed_rows[row].data, directed_rows[row].eos,
                      directed_rows[row].pin, pinned);
        end

        hold_armed = 1'b1;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            doc_bytes.delete();
            frags = $urandom_range(1, 10);
            repeat (frags) add_fragment();
            foreach (doc_bytes[k]) begin
                send_byte(doc_bytes[k], k == doc_bytes.size() - 1, 1'b0, pinned);
                random_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_out.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Output pacing: phases of changing readiness, plus one long hold-off
    // early in the random part so that the block backs up into its input.
    initial begin
        int    phase_left;
        bit    hold_done;
        pace_t pace;
        phase_left = 0;
        hold_done  = 1'b0;
        pace       = PACE_FULL;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                continue;
            end
            if (phase_left == 0) begin
                pace = pace_t'($urandom_range(0, 3));
                phase_left = $urandom_range(16, 80);
            end
            phase_left--;
            case (pace)
                PACE_FULL:   m_axis_tready <= 1'b1;
                PACE_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                PACE_SPARSE: m_axis_tready <= ($urandom_range(0, 9) == 0);
                default:     m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            failed = 1'b1;
        end
    endfunction

    // Each item taken from the output is held against the oldest expectation.
    always @(posedge i_clk) begin
        out_item_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_out.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual byte %0h user %0b",
                         $time, m_axis_tdata, m_axis_tuser);
                failed = 1'b1;
            end else begin
                want = expected_out.pop_front();
                compare_field("out_byte", want.data, m_axis_tdata);
                compare_field("has_byte", want.has_byte, m_axis_tuser[0]);
                compare_field("run_last", want.run_last, m_axis_tlast);
                compare_field("stream_done", want.done, m_axis_tuser[1]);
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
